/* rtl/lgi_pkg.sv */
// ----------------------------------------------------------------------------
// lgi_pkg
// Shared types and constants of the Lagrange interpolator.
// ----------------------------------------------------------------------------
package lgi_pkg;

  localparam int unsigned MaxNodesDef = 8;
  localparam logic [3:0]  CountReset  = 4'd4;
  localparam int unsigned FracBits    = 16;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_DUP = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [2:0]         node_index;
    logic signed [15:0] node_x;
    logic signed [15:0] node_y;
    logic signed [31:0] query_x;
  } lgi_in_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic [1:0]         status;
  } lgi_res_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLR_SUM,
    OP_INIT_TERM,
    OP_MUL_NUM,
    OP_MUL_DEN,
    OP_DIV_STEP,
    OP_ACC
  } lgi_op_e;

  typedef struct packed {
    lgi_op_e     op;
    logic        first;
    logic        neg;
    logic [31:0] factor;
  } lgi_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_I,
    ST_INIT,
    ST_RD_J,
    ST_FAC,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } lgi_state_e;

endpackage

/* rtl/lgi_node_mem.sv */
// ----------------------------------------------------------------------------
// lgi_node_mem
// Node table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lgi_node_mem #(
  parameter int unsigned MAX_NODES = lgi_pkg::MaxNodesDef,
  parameter int unsigned AW        = $clog2(MAX_NODES)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [MAX_NODES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/lgi_arith.sv */
// ----------------------------------------------------------------------------
// lgi_arith
// Wide numerator, denominator and sum registers with a shared 32x32 limb
// multiplier, a restoring divider step and the final saturation.
// ----------------------------------------------------------------------------
module lgi_arith #(
  parameter int unsigned MAX_NODES = lgi_pkg::MaxNodesDef,
  parameter int unsigned W         = (MAX_NODES + 1) * 32
) (
  input  logic               clk_i,
  input  lgi_pkg::lgi_ctl_t  ctl_i,
  output logic signed [47:0] value_o,
  output logic               sat_o
);
  import lgi_pkg::*;

  logic [W-1:0]  num_q, num_d;
  logic [W-1:0]  den_q, den_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  sum_q, sum_d;
  logic [31:0]   carry_q, carry_d;
  logic [31:0]   mul_a;
  logic [31:0]   carry_in;
  logic [63:0]   prod;
  logic [W-1:0]  rem_sh;
  logic          ge;
  logic [W-1:0]  term;
  logic          fits;

  // Each multiply step consumes the low limb and rotates the product in at
  // the top, so a full multiply is one pass over all limbs.
  assign mul_a    = (ctl_i.op == OP_MUL_DEN) ? den_q[31:0] : num_q[31:0];
  assign carry_in = ctl_i.first ? 32'd0 : carry_q;
  assign prod     = 64'(mul_a) * 64'(ctl_i.factor) + 64'(carry_in);

  assign rem_sh = {rem_q[W-2:0], num_q[W-1]};
  assign ge     = (rem_sh >= den_q);
  assign term   = ctl_i.neg ? (~num_q + W'(1)) : num_q;

  always_comb begin
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    sum_d   = sum_q;
    carry_d = carry_q;
    unique case (ctl_i.op)
      OP_CLR_SUM: begin
        sum_d = '0;
      end
      OP_INIT_TERM: begin
        num_d = W'(ctl_i.factor);
        den_d = W'(1);
        rem_d = '0;
      end
      OP_MUL_NUM: begin
        num_d   = {prod[31:0], num_q[W-1:32]};
        carry_d = prod[63:32];
      end
      OP_MUL_DEN: begin
        den_d   = {prod[31:0], den_q[W-1:32]};
        carry_d = prod[63:32];
      end
      OP_DIV_STEP: begin
        rem_d = ge ? (rem_sh - den_q) : rem_sh;
        num_d = {num_q[W-2:0], ge};
      end
      OP_ACC: begin
        sum_d = sum_q + term;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    sum_q   <= sum_d;
    carry_q <= carry_d;
  end

  assign fits  = (&sum_q[W-1:47]) | ~(|sum_q[W-1:47]);
  assign sat_o = ~fits;

  always_comb begin
    if (fits) begin
      value_o = sum_q[47:0];
    end else if (sum_q[W-1]) begin
      value_o = {1'b1, 47'd0};
    end else begin
      value_o = {1'b0, {47{1'b1}}};
    end
  end

endmodule

/* rtl/lagrange_interpolator.sv */
// ----------------------------------------------------------------------------
// lagrange_interpolator
// A load writes one node. An evaluate works on L = MAX_NODES + 1 limbs with one
// 32x32 multiplier and a one-bit divider step per cycle. One evaluate is in
// flight at a time; the result strobe cannot be stalled. Reset sets
// point_count to 4; the node table is not cleared.
// ----------------------------------------------------------------------------
module lagrange_interpolator #(
  parameter int unsigned MAX_NODES = lgi_pkg::MaxNodesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lgi_pkg::lgi_in_t  in_i,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  output logic              done_o,
  output lgi_pkg::lgi_res_t res_o
);
  import lgi_pkg::*;

  localparam int unsigned LIMBS = MAX_NODES + 1;
  localparam int unsigned W     = LIMBS * 32;
  localparam int unsigned AW    = $clog2(MAX_NODES);
  localparam int unsigned CW    = $clog2(MAX_NODES + 1);
  localparam int unsigned KW    = $clog2(W);

  lgi_state_e state_q, state_d;
  logic [3:0]         pc_q;
  logic [CW-1:0]      m_q, i_q, j_q;
  logic [KW-1:0]      k_q;
  logic signed [31:0] q_q;
  logic signed [15:0] xi_q;
  logic               neg_q, dup_q;
  logic [31:0]        fnum_q, fden_q;

  logic               mem_we;
  logic [AW-1:0]      mem_raddr;
  logic [31:0]        mem_rdata;
  lgi_ctl_t           ctl;
  logic signed [47:0] value;
  logic               sat;

  logic [4:0]         m_full;
  logic signed [15:0] rd_x, rd_y;
  logic signed [32:0] qd;
  logic [32:0]        qd_abs;
  logic signed [16:0] dx;
  logic [16:0]        dx_abs;
  logic [15:0]        y_abs;
  logic               limb_last, div_last;

  assign rd_x = mem_rdata[31:16];
  assign rd_y = mem_rdata[15:0];
  assign qd   = {q_q[31], q_q} - {rd_x[15], rd_x, 16'd0};
  assign qd_abs = qd[32] ? (~qd + 33'd1) : qd;
  assign dx   = {xi_q[15], xi_q} - {rd_x[15], rd_x};
  assign dx_abs = dx[16] ? (~dx + 17'd1) : dx;
  assign y_abs  = rd_y[15] ? (~rd_y + 16'd1) : rd_y;
  assign limb_last = (k_q == KW'(LIMBS - 1));
  assign div_last  = (k_q == KW'(W - 1));

  always_comb begin
    if (pc_q == 4'd0) begin
      m_full = 5'd1;
    end else if ({1'b0, pc_q} > 5'(MAX_NODES)) begin
      m_full = 5'(MAX_NODES);
    end else begin
      m_full = {1'b0, pc_q};
    end
  end

  assign mem_we = start && !busy && (in_i.cmd == CMD_LOAD) &&
                  (32'(in_i.node_index) < MAX_NODES);

  lgi_node_mem #(.MAX_NODES(MAX_NODES), .AW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(AW'(in_i.node_index)),
    .wdata_i({in_i.node_x, in_i.node_y}),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  lgi_arith #(.MAX_NODES(MAX_NODES), .W(W)) u_arith (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .value_o(value),
    .sat_o  (sat)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && (in_i.cmd == CMD_EVAL)) state_d = ST_RD_I;
      end
      ST_RD_I: state_d = ST_INIT;
      ST_INIT: state_d = ST_RD_J;
      ST_RD_J: begin
        if (j_q == m_q) begin
          state_d = ST_DIV;
        end else if (j_q != i_q) begin
          state_d = ST_FAC;
        end
      end
      ST_FAC: state_d = ST_MUL_NUM;
      ST_MUL_NUM: begin
        if (limb_last) state_d = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        if (limb_last) state_d = ST_RD_J;
      end
      ST_DIV: begin
        if (div_last) state_d = ST_ACC;
      end
      ST_ACC: state_d = (i_q + CW'(1) == m_q) ? ST_DONE : ST_RD_I;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    ctl        = '{op: OP_NONE, first: 1'b0, neg: neg_q, factor: fnum_q};
    mem_raddr  = i_q[AW-1:0];
    busy       = (state_q != ST_IDLE);
    done_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start && (in_i.cmd == CMD_EVAL)) ctl.op = OP_CLR_SUM;
      end
      ST_RD_I: mem_raddr = i_q[AW-1:0];
      ST_INIT: begin
        ctl.op     = OP_INIT_TERM;
        ctl.factor = {y_abs, 16'd0};
      end
      ST_RD_J: mem_raddr = j_q[AW-1:0];
      ST_MUL_NUM: begin
        ctl.op    = OP_MUL_NUM;
        ctl.first = (k_q == '0);
      end
      ST_MUL_DEN: begin
        ctl.op     = OP_MUL_DEN;
        ctl.first  = (k_q == '0);
        ctl.factor = fden_q;
      end
      ST_DIV: ctl.op = OP_DIV_STEP;
      ST_ACC: ctl.op = OP_ACC;
      ST_DONE: done_o = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    if (dup_q) begin
      res_o = '{value: 48'sd0, status: STATUS_DUP};
    end else if (sat) begin
      res_o = '{value: value, status: STATUS_SAT};
    end else begin
      res_o = '{value: value, status: STATUS_OK};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= CountReset;
      m_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      dup_q   <= 1'b0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) pc_q <= cfg_wdata_i;
      unique case (state_q)
        ST_IDLE: begin
          m_q   <= m_full[CW-1:0];
          i_q   <= '0;
          dup_q <= 1'b0;
        end
        ST_INIT: begin
          neg_q <= rd_y[15];
          j_q   <= '0;
        end
        ST_RD_J: begin
          k_q <= '0;
          if (j_q == i_q && j_q != m_q) j_q <= j_q + CW'(1);
        end
        ST_FAC: begin
          neg_q <= neg_q ^ qd[32] ^ dx[16];
          if (dx == 17'sd0) dup_q <= 1'b1;
        end
        ST_MUL_NUM: k_q <= limb_last ? '0 : k_q + KW'(1);
        ST_MUL_DEN: begin
          k_q <= limb_last ? '0 : k_q + KW'(1);
          if (limb_last) j_q <= j_q + CW'(1);
        end
        ST_DIV: k_q <= k_q + KW'(1);
        ST_ACC: i_q <= i_q + CW'(1);
        default: begin
        end
      endcase
    end
  end

  // Evaluation operands; no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) q_q <= in_i.query_x;
    if (state_q == ST_INIT) xi_q <= rd_x;
    if (state_q == ST_FAC) begin
      fnum_q <= qd_abs[31:0];
      fden_q <= {dx_abs[15:0], 16'd0};
    end
  end

`ifndef SYNTH
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("result strobe not followed by idle");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !mem_we)
    else $error("node table written during evaluation");
  a_dup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == STATUS_DUP) |-> (res_o.value == 48'sd0))
    else $error("duplicate abscissa with nonzero value");
  a_term_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && state_q != ST_DONE) |-> (i_q < m_q))
    else $error("term index beyond point count");
  a_eval_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !div_last) |=> (state_q == ST_DIV))
    else $error("division left early");
`endif

endmodule
